### rtl/u16mg_pkg.sv
// Shared types, constants and helper functions for the 16-bit wrapping gain block.
// Used by the top level and the assertion checker; depends on nothing.

package u16mg_pkg;

	// Sizes of the gain matrix and data path.
	localparam int MAX_ROWS  = 4;
	localparam int MAX_INNER = 4;
	localparam int DATA_W    = 16;
	localparam int ROW_W     = 2;
	localparam int CNT_W     = 3;
	localparam int GAIN_W    = DATA_W * MAX_INNER;
	localparam int CFG_IDX_W = 3;
	localparam int BANKS     = 2;
	localparam int BANK_W    = 1;

	typedef logic [DATA_W-1:0] word_t;
	typedef word_t [MAX_ROWS-1:0] lanes_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALAR_MODE = 3'd0,
		REG_GAIN_ROWS   = 3'd1,
		REG_GAIN_COLS   = 3'd2,
		REG_GAIN_ROW_0  = 3'd3,
		REG_GAIN_ROW_1  = 3'd4,
		REG_GAIN_ROW_2  = 3'd5,
		REG_GAIN_ROW_3  = 3'd6
	} cfg_reg_e;

	// Clamp a row or column count to 1..hi and return it minus one.
	function automatic logic [ROW_W-1:0] clamp_m1(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] hi);
		logic [CNT_W-1:0] t;
		if (v == '0) begin
			t = CNT_W'(1);
		end else if (v > hi) begin
			t = hi;
		end else begin
			t = v;
		end
		return ROW_W'(t - CNT_W'(1));
	endfunction

	// Pick the gain of one column out of a packed matrix row.
	function automatic word_t gain_sel(input logic [GAIN_W-1:0] row,
			input logic [ROW_W-1:0] col);
		return row[col*DATA_W +: DATA_W];
	endfunction

	// Low half of an unsigned product.
	function automatic word_t mul_lo(input word_t a, input word_t b);
		logic [2*DATA_W-1:0] p;
		p = a * b;
		return p[DATA_W-1:0];
	endfunction

endpackage

### rtl/u16mg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.

module u16mg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/uint16_matrix_gain_wrap.sv
// Top level of the 16-bit wrapping gain: scalar gain or 4x4 matrix times column.
// Depends on u16mg_pkg and the generic RAM u16mg_ram.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------
//   input    | in        | in_valid / in_stall    | sample
//   output   | out       | out_valid / out_stall  | result, out_row, last
//   config   | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// One sample per cycle while in_stall is low; row sums live in a two-bank RAM (one bank per column in flight),
// read at acceptance, added next cycle and written back with a forward from the last write.
// The first result of a burst is offered from the stage 2 register once its sample has passed stage 1,
// then one per cycle while out_stall is low. A column that ends while the burst ahead is still
// out holds the input until that burst's last result is taken. Reset clears control
// state; the RAM needs no clearing pass (per-bank valid bits).

module uint16_matrix_gain_wrap
	import u16mg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_W-1:0]     sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_W-1:0]     result,
	output logic [ROW_W-1:0]      out_row,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [GAIN_W-1:0]     cfg_data
);

	// Configuration registers.
	logic               scalar_mode_q;
	logic [CNT_W-1:0]   gain_rows_q;
	logic [CNT_W-1:0]   gain_cols_q;
	logic [GAIN_W-1:0]  gain_q [MAX_ROWS];

	// Column tracking and bank control.
	logic [ROW_W-1:0]   count_q;
	logic [BANK_W-1:0]  bank_q;
	logic [BANKS-1:0]   ent_valid_q;

	// Stage 1: accumulate and write back.
	logic               valid_s1;
	logic               scalar_s1;
	logic               eoc_s1;
	logic               done_s1;
	logic               evalid_s1;
	logic [ROW_W-1:0]   rows_m1_s1;
	logic [BANK_W-1:0]  addr_s1;
	lanes_t             prod_s1;

	// Forward path from the last RAM write.
	logic               fwd_valid_q;
	logic [BANK_W-1:0]  fwd_addr_q;
	lanes_t             fwd_data_q;

	// Stage 2: output burst register.
	logic               valid_s2;
	logic [ROW_W-1:0]   rows_m1_s2;
	logic [ROW_W-1:0]   idx_s2;
	lanes_t             vals_s2;

	logic               accept;
	logic [ROW_W-1:0]   rows_m1;
	logic [ROW_W-1:0]   cols_m1;
	logic               eoc_s0;
	lanes_t             prod_s0;
	lanes_t             ram_rdata;
	lanes_t             base;
	lanes_t             acc;
	lanes_t             out_vals;
	lanes_t             ram_wdata;
	logic               ram_we;
	logic               has_out_s1;
	logic               s1_adv;
	logic               s2_free;
	logic               load_s2;
	logic               out_xfer;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scalar_mode_q <= 1'b1;
			gain_rows_q   <= CNT_W'(1);
			gain_cols_q   <= CNT_W'(1);
			gain_q[0]     <= GAIN_W'(1);
			gain_q[1]     <= '0;
			gain_q[2]     <= '0;
			gain_q[3]     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALAR_MODE: scalar_mode_q <= cfg_data[0];
				REG_GAIN_ROWS:   gain_rows_q   <= cfg_data[CNT_W-1:0];
				REG_GAIN_COLS:   gain_cols_q   <= cfg_data[CNT_W-1:0];
				REG_GAIN_ROW_0:  gain_q[0]     <= cfg_data;
				REG_GAIN_ROW_1:  gain_q[1]     <= cfg_data;
				REG_GAIN_ROW_2:  gain_q[2]     <= cfg_data;
				REG_GAIN_ROW_3:  gain_q[3]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input side: clamp counts and multiply the sample by each row's gain.
	assign accept  = in_valid && !in_stall;
	assign rows_m1 = clamp_m1(gain_rows_q, CNT_W'(MAX_ROWS));
	assign cols_m1 = clamp_m1(gain_cols_q, CNT_W'(MAX_INNER));
	assign eoc_s0  = (count_q >= cols_m1);

	always_comb begin
		for (int r = 0; r < MAX_ROWS; r++) begin
			prod_s0[r] = mul_lo(gain_sel(gain_q[r], scalar_mode_q ? '0 : count_q), sample);
		end
	end

	// Column position and bank; scalar samples leave them alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q  <= '0;
		end else if (accept && !scalar_mode_q) begin
			if (eoc_s0) begin
				count_q <= '0;
				bank_q  <= ~bank_q;
			end else begin
				count_q <= count_q + ROW_W'(1);
			end
		end
	end

	// Row sum storage, one bank per column.
	u16mg_ram #(
		.WIDTH (DATA_W * MAX_ROWS),
		.DEPTH (BANKS)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.raddr (bank_q),
		.rdata (ram_rdata)
	);

	// Stage 1 arithmetic: old sums from forward, RAM or reset value, plus products.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			base = fwd_data_q;
		end else if (evalid_s1) begin
			base = ram_rdata;
		end else begin
			base = '0;
		end
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (ROW_W'(r) <= rows_m1_s1) begin
				acc[r] = base[r] + prod_s1[r];
			end else begin
				acc[r] = base[r];
			end
		end
		out_vals  = (scalar_s1 || done_s1) ? prod_s1 : acc;
		ram_we    = valid_s1 && !scalar_s1 && !done_s1;
		ram_wdata = eoc_s1 ? '0 : acc;
	end

	// Stage 1 hands over only when the output register is free.
	assign out_xfer   = out_valid && !out_stall;
	assign s2_free    = !valid_s2 || (out_xfer && last);
	assign has_out_s1 = scalar_s1 || eoc_s1;
	assign s1_adv     = !has_out_s1 || s2_free;
	assign load_s2    = valid_s1 && has_out_s1 && s2_free;
	assign in_stall   = valid_s1 && !s1_adv;

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			done_s1  <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			valid_s1 <= 1'b0;
			done_s1  <= 1'b0;
		end else if (valid_s1) begin
			done_s1  <= 1'b1;
		end
	end

	// Stage 1 payload; a stalled column keeps its finished sums in place.
	always_ff @(posedge clk) begin
		if (accept) begin
			scalar_s1  <= scalar_mode_q;
			eoc_s1     <= eoc_s0;
			rows_m1_s1 <= rows_m1;
			addr_s1    <= bank_q;
			evalid_s1  <= ent_valid_q[bank_q];
			prod_s1    <= prod_s0;
		end else if (valid_s1 && !s1_adv && !done_s1 && !scalar_s1) begin
			prod_s1    <= acc;
		end
	end

	// Forward register and per-bank valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			ent_valid_q <= '0;
		end else begin
			fwd_valid_q <= ram_we;
			if (ram_we) begin
				ent_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= ram_wdata;
	end

	// Output burst control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (out_xfer) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			vals_s2    <= out_vals;
			rows_m1_s2 <= scalar_s1 ? '0 : rows_m1_s1;
		end
	end

	assign out_valid = valid_s2;
	assign result    = vals_s2[idx_s2];
	assign out_row   = idx_s2;
	assign last      = (idx_s2 == rows_m1_s2);

endmodule

### rtl/u16mg_checker.sv
// Port-level assertions for the 16-bit wrapping gain block, bound to its top level.
// Depends on u16mg_pkg and uint16_matrix_gain_wrap.

module u16mg_checker
	import u16mg_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [DATA_W-1:0]  result,
	input logic [ROW_W-1:0]   out_row,
	input logic               last
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(out_row)
			&& $stable(last))
		else $error("stalled result changed");

	// A burst does not break off before its last result.
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("burst ended without last");

	// Rows of a burst come out in order.
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_row == ROW_W'($past(out_row) + ROW_W'(1)))
		else $error("row index did not advance by one");

	// The highest row always closes its burst.
	a_top_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_row == ROW_W'(MAX_ROWS - 1)) |-> last)
		else $error("top row not marked last");

endmodule

bind uint16_matrix_gain_wrap u16mg_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result),
	.out_row   (out_row),
	.last      (last)
);
